// ===== rtl/core/vec4_length_normalise_unit_macros.svh =====
// Assertion macros used by the vector unit checker.
// Depends on nothing; expects clk and rst in the scope of use.
`ifndef VEC4_LENGTH_NORMALISE_UNIT_MACROS_SVH
`define VEC4_LENGTH_NORMALISE_UNIT_MACROS_SVH

// Property checked every clock edge outside reset.
`define VLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on the edge after the trigger.
`define VLN_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);

`endif

// ===== rtl/core/vln_pkg.sv =====
// Shared types and constants for the four-component vector unit.
// No dependencies.
`default_nettype none
package vln_pkg;
  // Operation codes
  typedef enum logic [2:0] {
    OP_NORM    = 3'd0,
    OP_MAG     = 3'd1,
    OP_MAG_SQ  = 3'd2,
    OP_DIST    = 3'd3,
    OP_DIST_SQ = 3'd4
  } op_t;

  localparam int QBITS   = 14;          // fraction bits of normalized result
  localparam int QW      = QBITS + 1;   // quotient width, covers 1.0
  localparam int SCALARW = 34;
  localparam int NORMW   = 16;
endpackage
`default_nettype wire

// ===== rtl/core/vec4_length_normalise_unit.sv =====
// Four-component vector normalize / length / distance unit, top level.
// Depends on vln_pkg, vln_lane, vln_sqrt and vln_div.
//
// Input channel in_valid/in_ready carries op and vectors a, b (signed Q8.8).
// Output channel out_valid/out_ready carries nx..nw (Q1.14), scalar and
// was_zero, one result per input transaction, in order.
// cfg_we writes zero_threshold from cfg_wdata at once; write only when idle.
// The pipeline has two lane stages, one sum stage,
// COMPONENT_WIDTH + 2 root stages (one root bit each), 15 divider stages
// (one quotient bit each) and the output register.
// Throughput is one transaction per cycle while the receiver takes results.
// When the receiver stalls with a result held, the whole pipeline holds
// and in_ready drops; in_ready stays high while the output register is
// empty or being taken.
// Reset (rst, synchronous) empties the pipeline and clears zero_threshold.
`default_nettype none
module vec4_length_normalise_unit #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [15:0]                cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 op,
  input  wire logic [COMPONENT_WIDTH-1:0] ax,
  input  wire logic [COMPONENT_WIDTH-1:0] ay,
  input  wire logic [COMPONENT_WIDTH-1:0] az,
  input  wire logic [COMPONENT_WIDTH-1:0] aw,
  input  wire logic [COMPONENT_WIDTH-1:0] bx,
  input  wire logic [COMPONENT_WIDTH-1:0] by,
  input  wire logic [COMPONENT_WIDTH-1:0] bz,
  input  wire logic [COMPONENT_WIDTH-1:0] bw,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [15:0]                     nx,
  output logic [15:0]                     ny,
  output logic [15:0]                     nz,
  output logic [15:0]                     nw,
  output logic [33:0]                     scalar,
  output logic                            was_zero
);
  localparam int W      = COMPONENT_WIDTH;
  localparam int MW     = W + 1;
  localparam int SQW    = 2 * MW;
  localparam int SW     = SQW + 2;
  localparam int RW     = SW / 2;
  localparam int QW     = vln_pkg::QW;
  localparam int NW     = vln_pkg::NORMW;
  localparam int SCW    = vln_pkg::SCALARW;
  localparam int SIDE_W = 3 + 1 + 4 * MW + 4 + SW;
  localparam int L      = 3 + RW + QW;

  logic [15:0]  zero_threshold;
  logic         ce;
  logic [L-1:0] vld;
  logic         is_dist;

  logic [W-1:0] a_in [0:3];
  logic [W-1:0] b_in [0:3];
  logic [SQW-1:0] sq  [0:3];
  logic [MW-1:0]  mag [0:3];
  logic [3:0]     neg;

  logic [2:0]     op_s1, op_s2, op_s3;
  logic [SW-1:0]  sum_s3;
  logic           zero_s3;
  logic [MW-1:0]  mag_s3 [0:3];
  logic [3:0]     neg_s3;

  logic [SIDE_W-1:0] side_in, side_out;
  logic [RW-1:0]     root;
  logic [RW-1:0]     root_div;
  logic [2:0]        op_r;
  logic              zero_r;
  logic [SW-1:0]     sum_r;
  logic [MW-1:0]     mag_r [0:3];
  logic [3:0]        neg_r;
  logic [SCW-1:0]    scalar_r;

  logic [QW-1:0] quot [0:3];
  logic [3:0]    qneg;

  typedef struct packed {
    logic           norm_ok;
    logic           zero_hit;
    logic [SCW-1:0] sc;
  } meta_t;
  meta_t meta_in;
  meta_t meta_q [0:QW-1];

  logic [NW-1:0] nrm [0:3];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= '0;
    end else if (cfg_we) begin
      zero_threshold <= cfg_wdata;
    end
  end

  // global advance: output register empty or being taken
  assign ce       = !out_valid || out_ready;
  assign in_ready = ce;
  assign is_dist  = (op == vln_pkg::OP_DIST) || (op == vln_pkg::OP_DIST_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  assign a_in[0] = ax; assign a_in[1] = ay; assign a_in[2] = az; assign a_in[3] = aw;
  assign b_in[0] = bx; assign b_in[1] = by; assign b_in[2] = bz; assign b_in[3] = bw;

  // component lanes
  for (genvar i = 0; i < 4; i++) begin : g_lane
    vln_lane #(.W(W)) u_lane (
      .clk     (clk),
      .ce      (ce),
      .a       (a_in[i]),
      .b       (b_in[i]),
      .is_dist (is_dist),
      .sq      (sq[i]),
      .mag     (mag[i]),
      .neg     (neg[i])
    );
  end

  // op follows the lane stages
  always_ff @(posedge clk) begin
    if (ce) begin
      op_s1 <= op;
      op_s2 <= op_s1;
    end
  end

  // merge: sum of squares and zero test
  always_ff @(posedge clk) begin
    if (ce) begin
      sum_s3  <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
      zero_s3 <= (SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]))
                 <= SW'(zero_threshold);
      op_s3   <= op_s2;
      neg_s3  <= neg;
      for (int i = 0; i < 4; i++) begin
        mag_s3[i] <= mag[i];
      end
    end
  end

  assign side_in = {op_s3, zero_s3, mag_s3[0], mag_s3[1], mag_s3[2], mag_s3[3],
                    neg_s3, sum_s3};

  vln_sqrt #(.SW(SW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .ce       (ce),
    .radicand (sum_s3),
    .side_in  (side_in),
    .root     (root),
    .side_out (side_out)
  );

  assign {op_r, zero_r, mag_r[0], mag_r[1], mag_r[2], mag_r[3], neg_r, sum_r} = side_out;
  assign root_div = (root == '0) ? RW'(1) : root;

  // scalar per op
  always_comb begin
    logic [SW+SCW-1:0] sum_ext;
    logic [RW+SCW-1:0] root_ext;
    sum_ext  = {{SCW{1'b0}}, sum_r};
    root_ext = {{SCW{1'b0}}, root};
    if ((op_r == vln_pkg::OP_MAG) || (op_r == vln_pkg::OP_DIST)) begin
      scalar_r = root_ext[SCW-1:0];
    end else if ((op_r == vln_pkg::OP_MAG_SQ) || (op_r == vln_pkg::OP_DIST_SQ)) begin
      scalar_r = sum_ext[SCW-1:0];
    end else begin
      scalar_r = '0;
    end
  end

  assign meta_in.norm_ok  = (op_r == vln_pkg::OP_NORM) && !zero_r;
  assign meta_in.zero_hit = (op_r == vln_pkg::OP_NORM) && zero_r;
  assign meta_in.sc       = scalar_r;

  // divider lanes
  for (genvar i = 0; i < 4; i++) begin : g_div
    vln_div #(.MW(MW), .RW(RW)) u_div (
      .clk      (clk),
      .ce       (ce),
      .mag      (mag_r[i]),
      .neg      (neg_r[i]),
      .root     (root_div),
      .quot     (quot[i]),
      .quot_neg (qneg[i])
    );
  end

  // per-item info delayed alongside the dividers
  always_ff @(posedge clk) begin
    if (ce) begin
      meta_q[0] <= meta_in;
      for (int k = 1; k < QW; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // signed normalized components
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!meta_q[QW-1].norm_ok) begin
        nrm[i] = '0;
      end else if (qneg[i]) begin
        nrm[i] = NW'(-{1'b0, quot[i]});
      end else begin
        nrm[i] = NW'({1'b0, quot[i]});
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce && vld[L-1]) begin
      nx       <= nrm[0];
      ny       <= nrm[1];
      nz       <= nrm[2];
      nw       <= nrm[3];
      scalar   <= meta_q[QW-1].sc;
      was_zero <= meta_q[QW-1].zero_hit;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/vln_lane.sv =====
// One component lane: difference, magnitude and square, two stages.
// Depends on nothing beyond its ports.
`default_nettype none
module vln_lane #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                ce,
  input  wire logic [W-1:0]        a,
  input  wire logic [W-1:0]        b,
  input  wire logic                is_dist,
  output logic      [2*W+1:0]      sq,
  output logic      [W:0]          mag,
  output logic                     neg
);
  logic signed [W:0] diff;
  logic        [W:0] mag_s1;
  logic              neg_s1;

  // component or difference, one bit wider
  always_comb begin
    if (is_dist) begin
      diff = $signed({a[W-1], a}) - $signed({b[W-1], b});
    end else begin
      diff = $signed({a[W-1], a});
    end
  end

  // stage 1: magnitude and sign
  always_ff @(posedge clk) begin
    if (ce) begin
      neg_s1 <= diff[W];
      mag_s1 <= diff[W] ? (W+1)'(-diff) : diff;
    end
  end

  // stage 2: square
  always_ff @(posedge clk) begin
    if (ce) begin
      sq  <= mag_s1 * mag_s1;
      mag <= mag_s1;
      neg <= neg_s1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/vln_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, with sideband.
// Depends on nothing beyond its ports.
`default_nettype none
module vln_sqrt #(
  parameter int SW     = 36,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              ce,
  input  wire logic [SW-1:0]     radicand,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic      [SW/2-1:0]   root,
  output logic      [SIDE_W-1:0] side_out
);
  localparam int RW   = SW / 2;
  localparam int REMW = RW + 3;

  logic [REMW-1:0]   rem_q  [0:RW];
  logic [RW-1:0]     root_q [0:RW];
  logic [SW-1:0]     rad_q  [0:RW];
  logic [SIDE_W-1:0] side_q [0:RW];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign rad_q[0]  = radicand;
  assign side_q[0] = side_in;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [REMW-1:0] rsh;
    logic [REMW-1:0] trial;
    logic            take;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      rsh   = {rem_q[k][REMW-3:0], rad_q[k][SW-1-2*k -: 2]};
      trial = REMW'({root_q[k], 2'b01});
      take  = (rsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[k+1]  <= take ? rsh - trial : rsh;
        root_q[k+1] <= {root_q[k][RW-2:0], take};
        rad_q[k+1]  <= rad_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign root     = root_q[RW];
  assign side_out = side_q[RW];
endmodule
`default_nettype wire

// ===== rtl/core/vln_div.sv =====
// Per-lane restoring divider: (mag << 14) / root, one quotient bit per stage.
// Depends on vln_pkg for the quotient width.
`default_nettype none
module vln_div #(
  parameter int MW = 17,
  parameter int RW = 18
) (
  input  wire logic                   clk,
  input  wire logic                   ce,
  input  wire logic [MW-1:0]          mag,
  input  wire logic                   neg,
  input  wire logic [RW-1:0]          root,
  output logic      [vln_pkg::QW-1:0] quot,
  output logic                        quot_neg
);
  localparam int NS = vln_pkg::QW;

  logic [RW:0]   rem_q  [0:NS];
  logic [RW-1:0] div_q  [0:NS];
  logic [NS-1:0] quo_q  [0:NS];
  logic          neg_q  [0:NS];

  // magnitude never exceeds root, so it fits the remainder as is
  assign rem_q[0] = (RW+1)'(mag);
  assign div_q[0] = root;
  assign quo_q[0] = '0;
  assign neg_q[0] = neg;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [RW:0] cur;
    logic        ge;

    // first stage yields the integer bit, later ones shift in zeros
    always_comb begin
      if (j == 0) begin
        cur = rem_q[j];
      end else begin
        cur = {rem_q[j][RW-1:0], 1'b0};
      end
      ge = (cur >= {1'b0, div_q[j]});
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_q[j+1] <= ge ? cur - {1'b0, div_q[j]} : cur;
        quo_q[j+1] <= {quo_q[j][NS-2:0], ge};
        div_q[j+1] <= div_q[j];
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  assign quot     = quo_q[NS];
  assign quot_neg = neg_q[NS];
endmodule
`default_nettype wire

// ===== rtl/core/vln_checker.sv =====
// Port-level checks for the vector unit, bound to the top level.
// Depends on vec4_length_normalise_unit_macros.svh.
`default_nettype none
`include "vec4_length_normalise_unit_macros.svh"
module vln_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] nx,
  input wire logic [15:0] ny,
  input wire logic [15:0] nz,
  input wire logic [15:0] nw,
  input wire logic [33:0] scalar,
  input wire logic        was_zero
);
  // a stalled result stays put
  `VLN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(scalar), "result dropped while stalled")
  // input side never blocks while the output register is free
  `VLN_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty output")
  // zero result carries no vector and no scalar
  `VLN_ASSERT(a_zero_clean, (out_valid && was_zero) |-> (nx == 16'd0 && ny == 16'd0 && nz == 16'd0 && nw == 16'd0 && scalar == 34'd0), "zero flag with nonzero payload")
  // normalized result never also carries a scalar
  `VLN_ASSERT(a_norm_excl, (out_valid && (nx != 16'd0 || ny != 16'd0 || nz != 16'd0 || nw != 16'd0)) |-> (scalar == 34'd0 && !was_zero), "vector and scalar both set")
endmodule

bind vec4_length_normalise_unit vln_checker u_vln_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .nx        (nx),
  .ny        (ny),
  .nz        (nz),
  .nw        (nw),
  .scalar    (scalar),
  .was_zero  (was_zero)
);
`default_nettype wire
